FILE: rtl/core/stha_pkg.sv
// Shared commands, status codes and scan control types for the slot table allocator.
`timescale 1ns / 1ps

package stha_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_MISS = 2'd2;

    // what a scanned entry must hold to stop the scan
    localparam logic [1:0] SCAN_ZERO    = 2'd0;
    localparam logic [1:0] SCAN_KEY     = 2'd1;
    localparam logic [1:0] SCAN_NONZERO = 2'd2;
    localparam logic [1:0] SCAN_ANY     = 2'd3;

    typedef struct packed {
        logic       down;
        logic [1:0] mode;
    } t_scan_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_rsp;

endpackage

FILE: rtl/core/slot_table_handle_allocator_top.sv
// Slot table handle allocator: command sequencer, mark and free pointer, result register.
`timescale 1ns / 1ps
// Read fetches its slot with a one-slot scan; append rescans for the free pointer when it
// filled a hole below the mark; remove runs a forward match scan, then a backward trim scan,
// one slot per cycle each through the single slot memory read port.
// One item at a time; the next item is taken while the previous result waits at the output.
// After reset the slot memory is swept to zero, with no item accepted during the sweep.

module slot_table_handle_allocator_top
    import stha_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_handle,
    input  logic [5:0]  i_slot_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_placed_index,
    output logic [6:0]  o_high_water,
    output logic [31:0] o_read_handle,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_ASCAN  = 3'd2;
    localparam logic [2:0] S_RSCAN  = 3'd3;
    localparam logic [2:0] S_RTRIM  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_mark, n_mark;
    logic [PW-1:0] r_free, n_free;
    logic [1:0]    r_cmd;
    logic [31:0]   r_handle;
    logic [5:0]    r_idx;
    logic [AW-1:0] r_placed, n_placed;
    logic [31:0]   r_rd, n_rd;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_hit, n_hit;

    logic          r_o_valid;
    logic [5:0]    r_o_placed;
    logic [6:0]    r_o_hw;
    logic [31:0]   r_o_rd;
    logic [1:0]    r_o_status;

    logic          tbl_ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          scan_start;
    t_scan_ctl     scan_ctl;
    logic [AW-1:0] scan_base;
    logic [PW-1:0] scan_len;
    t_scan_rsp     scan_rsp;
    logic [AW-1:0] scan_index;
    logic [31:0]   scan_data;

    logic          in_acc;
    logic          out_load;
    logic [PW-1:0] fp;
    logic [PW-1:0] trim_mark;
    logic [PW-1:0] hit_ptr;
    logic [PW-1:0] rep_free;
    logic [31:0]   placed_ext;
    logic [31:0]   mark_ext;

    stha_table #(
        .CAPACITY (CAPACITY)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_ready      (tbl_ready),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_scan_start (scan_start),
        .i_scan_ctl   (scan_ctl),
        .i_scan_base  (scan_base),
        .i_scan_len   (scan_len),
        .i_scan_key   (r_handle),
        .o_scan_rsp   (scan_rsp),
        .o_scan_index (scan_index),
        .o_scan_data  (scan_data)
    );

    assign o_in_ready = (r_state == S_IDLE) && tbl_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_o_valid || i_out_ready);

    assign fp        = (r_free < r_mark) ? r_free : r_mark;
    assign trim_mark = scan_rsp.found ? PW'(scan_index) + 1'b1 : '0;
    assign hit_ptr   = PW'(r_hit);

    // free pointer repair after remove: min with the cleared slot, clamp to the new mark
    always_comb begin
        rep_free = (hit_ptr < r_free) ? hit_ptr : r_free;
        if (rep_free > trim_mark) begin
            rep_free = trim_mark;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mark     = r_mark;
        n_free     = r_free;
        n_placed   = r_placed;
        n_rd       = r_rd;
        n_status   = r_status;
        n_hit      = r_hit;
        wr_en      = 1'b0;
        wr_addr    = AW'(fp);
        wr_data    = r_handle;
        scan_start = 1'b0;
        scan_ctl   = '{down: 1'b0, mode: SCAN_ANY};
        scan_base  = '0;
        scan_len   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_placed = '0;
                    n_rd     = 32'd0;
                    n_status = STS_OK;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_APPEND: begin
                        if (r_handle == 32'd0) begin
                            n_state = S_DONE;
                        end else if (fp >= PW'(CAPACITY)) begin
                            n_status = STS_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            n_placed = AW'(fp);
                            if (fp == r_mark) begin
                                n_mark = fp + 1'b1;
                                n_free = fp + 1'b1;
                            end else begin
                                scan_start = 1'b1;
                                scan_ctl   = '{down: 1'b0, mode: SCAN_ZERO};
                                scan_base  = AW'(fp + 1'b1);
                                scan_len   = r_mark - fp - 1'b1;
                                n_state    = S_ASCAN;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_handle == 32'd0 || r_mark == '0) begin
                            n_status = STS_MISS;
                        end else begin
                            scan_start = 1'b1;
                            scan_ctl   = '{down: 1'b0, mode: SCAN_KEY};
                            scan_base  = '0;
                            scan_len   = r_mark;
                            n_state    = S_RSCAN;
                        end
                    end
                    CMD_READ: begin
                        if (32'(r_idx) < 32'(CAPACITY)) begin
                            scan_start = 1'b1;
                            scan_ctl   = '{down: 1'b0, mode: SCAN_ANY};
                            scan_base  = AW'(r_idx);
                            scan_len   = PW'(1);
                            n_state    = S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ASCAN: begin
                if (scan_rsp.done) begin
                    n_free  = scan_rsp.found ? PW'(scan_index) : r_mark;
                    n_state = S_DONE;
                end
            end
            S_RSCAN: begin
                if (scan_rsp.done) begin
                    if (!scan_rsp.found) begin
                        n_status = STS_MISS;
                        n_state  = S_DONE;
                    end else begin
                        // clear the slot; the trim scan reads start after this write lands
                        wr_en      = 1'b1;
                        wr_addr    = scan_index;
                        wr_data    = 32'd0;
                        n_hit      = scan_index;
                        scan_start = 1'b1;
                        scan_ctl   = '{down: 1'b1, mode: SCAN_NONZERO};
                        scan_base  = AW'(r_mark - 1'b1);
                        scan_len   = r_mark;
                        n_state    = S_RTRIM;
                    end
                end
            end
            S_RTRIM: begin
                if (scan_rsp.done) begin
                    n_mark  = trim_mark;
                    n_free  = rep_free;
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                if (scan_rsp.done) begin
                    n_rd    = scan_data;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark  <= '0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_mark  <= n_mark;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_command;
            r_handle <= i_handle;
            r_idx    <= i_slot_index;
        end
        r_placed <= n_placed;
        r_rd     <= n_rd;
        r_status <= n_status;
        r_hit    <= n_hit;
    end

    assign placed_ext = 32'(r_placed);
    assign mark_ext   = 32'(r_mark);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_placed <= placed_ext[5:0];
            r_o_hw     <= mark_ext[6:0];
            r_o_rd     <= r_rd;
            r_o_status <= r_status;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_placed_index = r_o_placed;
    assign o_high_water   = r_o_hw;
    assign o_read_handle  = r_o_rd;
    assign o_status       = r_o_status;

endmodule

FILE: rtl/core/stha_table.sv
// Slot memory with post-reset clearing pass and a one-entry-per-cycle scan engine.
`timescale 1ns / 1ps

module stha_table
    import stha_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    output logic                             o_ready,
    input  logic                             i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0]      i_wr_addr,
    input  logic [31:0]                      i_wr_data,
    input  logic                             i_scan_start,
    input  t_scan_ctl                        i_scan_ctl,
    input  logic [$clog2(CAPACITY)-1:0]      i_scan_base,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_scan_len,
    input  logic [31:0]                      i_scan_key,
    output t_scan_rsp                        o_scan_rsp,
    output logic [$clog2(CAPACITY)-1:0]      o_scan_index,
    output logic [31:0]                      o_scan_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   r_rdata;

    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    logic          r_busy;
    logic [AW-1:0] r_addr;
    logic [PW-1:0] r_left;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    t_scan_ctl     r_ctl;
    logic [31:0]   r_key;

    logic          match;
    logic          hit;
    logic          done;
    logic          issue;
    logic          we;
    logic [AW-1:0] wa;
    logic [31:0]   wd;

    always_comb begin
        case (r_ctl.mode)
            SCAN_ZERO:    match = (r_rdata == 32'd0);
            SCAN_KEY:     match = (r_rdata == r_key);
            SCAN_NONZERO: match = (r_rdata != 32'd0);
            default:      match = 1'b1;
        endcase
    end

    assign hit   = r_busy && r_pend && match;
    assign done  = r_busy && (hit || (r_left == '0));
    assign issue = r_busy && !done && (r_left != '0);

    assign we = r_clr || i_wr_en;
    assign wa = r_clr ? r_clr_addr : i_wr_addr;
    assign wd = r_clr ? 32'd0 : i_wr_data;

    // read data is registered, from the address issued in the cycle before
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(CAPACITY - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_scan_start) begin
            r_busy <= 1'b1;
            r_pend <= 1'b0;
        end else if (r_busy) begin
            if (done) begin
                r_busy <= 1'b0;
            end
            r_pend <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan_start) begin
            r_addr <= i_scan_base;
            r_left <= i_scan_len;
            r_ctl  <= i_scan_ctl;
            r_key  <= i_scan_key;
        end else if (issue) begin
            r_addr      <= r_ctl.down ? r_addr - 1'b1 : r_addr + 1'b1;
            r_left      <= r_left - 1'b1;
            r_pend_addr <= r_addr;
        end
    end

    assign o_ready          = !r_clr;
    assign o_scan_rsp.done  = done;
    assign o_scan_rsp.found = hit;
    assign o_scan_index     = r_pend_addr;
    assign o_scan_data      = r_rdata;

endmodule

FILE: verif/slot_table_checker.sv
// Checker for the slot table allocator: tracks the table, predicts each result and compares it.
`timescale 1ns / 1ps

module slot_table_checker
    import stha_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_handle,
    input  logic [5:0]  i_slot_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_placed_index,
    input  logic [6:0]  i_high_water,
    input  logic [31:0] i_read_handle,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_checked
);

    typedef struct packed {
        logic [5:0]  placed;
        logic [6:0]  high_water;
        logic [31:0] read_handle;
        logic [1:0]  status;
    } t_slot_result;

    logic [31:0]  slots [CAPACITY];
    int           mark;
    int           free_ptr;
    t_slot_result due_results [$];
    int           fail_count;
    int           results_checked;

    // Applies one command to the shadow table and returns the result it must produce.
    function automatic t_slot_result apply_table_command(input logic [1:0] cmd,
                                                          input logic [31:0] h,
                                                          input logic [5:0] idx);
        t_slot_result r;
        int           fp;
        int           hit;
        int           i;
        r = '0;
        case (cmd)
            CMD_APPEND: begin
                fp = (free_ptr < mark) ? free_ptr : mark;
                if (h != 32'd0) begin
                    if (fp >= CAPACITY) begin
                        r.status = STS_FULL;
                    end else begin
                        slots[fp] = h;
                        r.placed  = 6'(fp);
                        if (fp == mark) begin
                            mark     = fp + 1;
                            free_ptr = fp + 1;
                        end else begin
                            // next hole below the mark, else the mark itself
                            while (fp < mark && fp < CAPACITY && slots[fp] != 32'd0)
                                fp++;
                            free_ptr = fp;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                hit = CAPACITY;
                if (h != 32'd0) begin
                    for (i = 0; i < mark && hit == CAPACITY; i++)
                        if (slots[i] == h)
                            hit = i;
                end
                if (hit >= CAPACITY) begin
                    r.status = STS_MISS;
                end else begin
                    slots[hit] = 32'd0;
                    while (mark > 0 && slots[mark - 1] == 32'd0)
                        mark--;
                    if (hit < free_ptr)
                        free_ptr = hit;
                    if (free_ptr > mark)
                        free_ptr = mark;
                end
            end
            CMD_READ: begin
                if (idx < CAPACITY)
                    r.read_handle = slots[idx];
            end
            default: ;
        endcase
        r.high_water = 7'(mark);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++)
                slots[i] = 32'd0;
            mark            = 0;
            free_ptr        = 0;
            fail_count      = 0;
            results_checked = 0;
            due_results.delete();
        end else begin
            // retire the output beat first: it always belongs to an earlier command
            if (i_out_valid && i_out_ready) begin
                got = '{i_placed_index, i_high_water, i_read_handle, i_status};
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result beat: placed=%0d hw=%0d rd=%h st=%0d",
                                 $realtime, got.placed, got.high_water, got.read_handle,
                                 got.status);
                end else begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result %0d mismatch: exp placed=%0d hw=%0d rd=%h ",
                                      "st=%0d, got placed=%0d hw=%0d rd=%h st=%0d"},
                                     $realtime, results_checked, want.placed,
                                     want.high_water, want.read_handle, want.status,
                                     got.placed, got.high_water, got.read_handle, got.status);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(apply_table_command(i_command, i_handle, i_slot_index));
        end
        o_fail_count      <= fail_count;
        o_pending         <= due_results.size();
        o_results_checked <= results_checked;
    end

endmodule

FILE: verif/tb_slot_table_handle_allocator_top.sv
// Testbench top for the slot table allocator: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module tb_slot_table_handle_allocator_top;
    import stha_pkg::*;

    localparam int         CAPACITY    = 64;
    localparam int         TARGET_CMDS = 1650;
    localparam int         DRAIN_WAIT  = 2 * CAPACITY + 12;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [31:0] i_handle;
    logic [5:0]  i_slot_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_placed_index;
    logic [6:0]  o_high_water;
    logic [31:0] o_read_handle;
    logic [1:0]  o_status;

    int          fail_count;
    int          pending;
    int          results_checked;

    int          cmd_count [4];
    int          sent_cmds;
    bit          steady;          // no idling on either side while set
    logic [31:0] live_handles [$];

    slot_table_handle_allocator_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_handle       (i_handle),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_placed_index (o_placed_index),
        .o_high_water   (o_high_water),
        .o_read_handle  (o_read_handle),
        .o_status       (o_status)
    );

    slot_table_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_handle          (i_handle),
        .i_slot_index      (i_slot_index),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_placed_index    (o_placed_index),
        .i_high_water      (o_high_water),
        .i_read_handle     (o_read_handle),
        .i_status          (o_status),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Drives one command beat; entered and left at a falling edge.
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] h, input logic [5:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_handle     <= h;
        i_slot_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        cmd_count[cmd]++;
        sent_cmds++;
    endtask

    task automatic append_handle(input logic [31:0] h);
        if (h != 32'd0 && live_handles.size() < CAPACITY)
            live_handles.push_back(h);
        send_cmd(CMD_APPEND, h, 6'($urandom));
    endtask

    // Removes a handle believed live, or a random one when none is known.
    task automatic remove_live;
        int k;
        logic [31:0] h;
        if (live_handles.size() == 0) begin
            h = $urandom;
        end else begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
        end
        send_cmd(CMD_REMOVE, h, 6'($urandom));
    endtask

    function automatic logic [31:0] fresh_handle;
        logic [31:0] h;
        case ($urandom_range(0, 9))
            0, 1:    h = 32'($urandom_range(1, 6));       // small values force duplicates
            2:       h = (live_handles.size() != 0) ?
                         live_handles[$urandom_range(0, live_handles.size() - 1)] : 32'd1;
            default: h = $urandom;
        endcase
        return h;
    endfunction

    task automatic random_cmd;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            append_handle(($urandom_range(0, 39) == 0) ? 32'd0 : fresh_handle());
        else if (pick < 70)
            case ($urandom_range(0, 9))
                0:       send_cmd(CMD_REMOVE, 32'd0, 6'($urandom));
                1, 2:    send_cmd(CMD_REMOVE, $urandom, 6'($urandom));
                default: remove_live();
            endcase
        else if (pick < 92)
            send_cmd(CMD_READ, $urandom, ($urandom_range(0, 1) != 0) ?
                     6'($urandom_range(0, 15)) : 6'($urandom));
        else
            send_cmd(CMD_UNUSED, $urandom, 6'($urandom));
    endtask

    // command channel
    initial begin
        int phase;
        int n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_APPEND;
        i_handle     = 32'd0;
        i_slot_index = 6'd0;
        steady       = 1'b0;
        sent_cmds    = 0;
        foreach (cmd_count[c])
            cmd_count[c] = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, zero handles, duplicates, holes, trimming of the mark
        send_cmd(CMD_READ, 32'd0, 6'd0);
        send_cmd(CMD_REMOVE, 32'd5, 6'd0);
        send_cmd(CMD_APPEND, 32'd0, 6'd0);
        send_cmd(CMD_REMOVE, 32'd0, 6'd0);
        send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_cmd(CMD_APPEND, 32'd1, 6'h3F);
        send_cmd(CMD_APPEND, 32'h8000_0000, 6'd0);
        send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_cmd(CMD_READ, 32'd0, 6'd0);
        send_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd3);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);  // lowest copy goes, mark stays
        send_cmd(CMD_READ, 32'd0, 6'd0);
        send_cmd(CMD_APPEND, 32'd7, 6'd0);          // fills the hole, pointer jumps to mark
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);  // top slot: mark trims down
        send_cmd(CMD_REMOVE, 32'h8000_0000, 6'd0);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(CMD_REMOVE, 32'd1, 6'd0);
        send_cmd(CMD_REMOVE, 32'd7, 6'd0);
        send_cmd(CMD_READ, 32'd0, 6'h3F);
        send_cmd(CMD_APPEND, 32'h5555_AAAA, 6'd0);
        send_cmd(CMD_APPEND, 32'hAAAA_5555, 6'd0);
        send_cmd(CMD_REMOVE, 32'h5555_AAAA, 6'd0);
        send_cmd(CMD_REMOVE, 32'hAAAA_5555, 6'd0);

        // random phases: fill up past full, drain, and mixed traffic
        phase = 0;
        while (sent_cmds < TARGET_CMDS) begin
            steady = ($urandom_range(0, 3) == 0);
            case (phase)
                0: begin
                    n = $urandom_range(20, 72);
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0)
                            send_cmd(CMD_READ, $urandom, 6'($urandom));
                        else
                            append_handle(fresh_handle());
                    end
                end
                1: begin
                    n = $urandom_range(10, 60);
                    repeat (n) begin
                        case ($urandom_range(0, 19))
                            0:       send_cmd(CMD_REMOVE, 32'd0, 6'($urandom));
                            1, 2:    send_cmd(CMD_REMOVE, $urandom, 6'($urandom));
                            3:       send_cmd(CMD_READ, $urandom, 6'($urandom));
                            default: remove_live();
                        endcase
                    end
                end
                default: repeat (40) random_cmd();
            endcase
            phase = $urandom_range(0, 3);
        end
        steady     = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run: %0d commands (%0d append, %0d remove, %0d read, %0d unused code)",
                 sent_cmds, cmd_count[CMD_APPEND], cmd_count[CMD_REMOVE],
                 cmd_count[CMD_READ], cmd_count[CMD_UNUSED]);
        $display("Run: %0d result beats compared, %0d mismatches, %0d still outstanding",
                 results_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result channel backpressure
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
